// ----- rtl/ksf_pkg.sv -----
`default_nettype none

package ksf_pkg;

    localparam int MAX_CONTIG    = 64;
    localparam int CONTIG_ADDR_W = 6;
    localparam int CONTIG_LEN_W  = 7;
    localparam int MAX_KMER      = 32;
    localparam int KMER_W        = 6;
    localparam int WIN_IDX_W     = 5;
    localparam int MAX_REFERENCE = 65536;
    localparam int REF_COUNT_W   = 17;
    localparam int REF_POS_W     = 16;
    localparam int SYMBOL_W      = 8;
    localparam int CMD_W         = 2;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = 2;
    localparam int M_TDATA_W     = 48;
    localparam int KMER_RESET    = 16;

    // command codes as they arrive on s_tuser
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CONTIG  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REF     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd3;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_CONTIG,
        OP_REF,
        OP_RESTART
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [SYMBOL_W-1:0] symbol;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } qhead_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } back_state_t;

    typedef struct packed {
        logic                     last_seed;
        logic [REF_POS_W-1:0]     ref_end;
        logic [REF_POS_W-1:0]     ref_start;
        logic [CONTIG_ADDR_W-1:0] contig_end;
        logic [CONTIG_ADDR_W-1:0] contig_start;
    } seed_t;

endpackage

`default_nettype wire

// ----- rtl/ksf_front.sv -----
`default_nettype none

module ksf_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [ksf_pkg::SYMBOL_W-1:0]  s_tdata,   // [7:0] symbol
    input  wire logic [ksf_pkg::CMD_W-1:0]     s_tuser,   // [1:0] command
    output ksf_pkg::qhead_t                    head,
    input  wire logic                          head_pop
);

    ksf_pkg::item_t                     queue_reg [ksf_pkg::QUEUE_DEPTH];
    logic [ksf_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [ksf_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [ksf_pkg::QUEUE_PTR_W:0]      fill_reg, fill_next;
    ksf_pkg::item_t                     in_item;
    logic                               push;
    logic                               pop;

    // classify the incoming command
    always_comb begin
        in_item.symbol = s_tdata;
        case (s_tuser)
            ksf_pkg::CMD_CLEAR:   in_item.op = ksf_pkg::OP_CLEAR;
            ksf_pkg::CMD_CONTIG:  in_item.op = ksf_pkg::OP_CONTIG;
            ksf_pkg::CMD_REF:     in_item.op = ksf_pkg::OP_REF;
            ksf_pkg::CMD_RESTART: in_item.op = ksf_pkg::OP_RESTART;
            default:              in_item.op = ksf_pkg::OP_RESTART;
        endcase
    end

    assign s_tready   = (fill_reg != (ksf_pkg::QUEUE_PTR_W+1)'(ksf_pkg::QUEUE_DEPTH));
    assign push       = s_tvalid && s_tready;
    assign head.valid = (fill_reg != '0);
    assign head.item  = queue_reg[rd_ptr_reg];
    assign pop        = head_pop && head.valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ksf_back.sv -----
`default_nettype none

module ksf_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [ksf_pkg::KMER_W-1:0]    k,
    input  wire ksf_pkg::qhead_t               head,
    output logic                               head_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output ksf_pkg::seed_t                     seed
);

    ksf_pkg::back_state_t state_reg, state_next;

    logic [ksf_pkg::SYMBOL_W-1:0]      mem [ksf_pkg::MAX_CONTIG];
    logic [ksf_pkg::SYMBOL_W-1:0]      rdata_reg;
    logic [ksf_pkg::CONTIG_ADDR_W-1:0] raddr;
    logic                              mem_we;

    logic [ksf_pkg::SYMBOL_W-1:0]      win_reg [ksf_pkg::MAX_KMER];
    logic                              win_shift;

    logic [ksf_pkg::CONTIG_LEN_W-1:0]  len_reg, len_next;
    logic [ksf_pkg::REF_COUNT_W-1:0]   count_reg, count_next;
    logic [ksf_pkg::CONTIG_LEN_W-1:0]  cp_reg, cp_next;
    logic [ksf_pkg::WIN_IDX_W-1:0]     ci_reg, ci_next;
    logic [ksf_pkg::CONTIG_ADDR_W-1:0] pend_reg, pend_next;
    logic                              pend_valid_reg, pend_valid_next;
    logic [ksf_pkg::REF_POS_W-1:0]     rstart_reg, rstart_next;
    logic                              m_valid_reg, m_valid_next;
    ksf_pkg::seed_t                    seed_reg, seed_next;

    logic [ksf_pkg::KMER_W-1:0]        widx_full;
    logic [ksf_pkg::REF_COUNT_W-1:0]   count_inc;
    logic                              eq, hit, adv_same, done, out_free, stall, start;
    logic [ksf_pkg::CONTIG_LEN_W-1:0]  np;
    logic [ksf_pkg::WIN_IDX_W-1:0]     ni;

    function automatic ksf_pkg::seed_t make_seed(
        input logic [ksf_pkg::CONTIG_ADDR_W-1:0] pos,
        input logic [ksf_pkg::REF_POS_W-1:0]     rs,
        input logic [ksf_pkg::KMER_W-1:0]        kk,
        input logic                              last
    );
        ksf_pkg::seed_t s;
        s.contig_start = pos;
        s.contig_end   = pos + ksf_pkg::CONTIG_ADDR_W'(kk) - 1'b1;
        s.ref_start    = rs;
        s.ref_end      = rs + ksf_pkg::REF_POS_W'(kk) - 1'b1;
        s.last_seed    = last;
        return s;
    endfunction

    // window slot that lines up with character ci of the current k-mer
    assign widx_full = ksf_pkg::KMER_W'(ksf_pkg::MAX_KMER) - k + ksf_pkg::KMER_W'(ci_reg);
    assign eq        = (rdata_reg == win_reg[widx_full[ksf_pkg::WIN_IDX_W-1:0]]);
    assign hit       = eq && (ksf_pkg::KMER_W'(ci_reg) == k - 1'b1);
    assign adv_same  = eq && !hit;
    assign np        = adv_same ? cp_reg : cp_reg + 1'b1;
    assign ni        = adv_same ? ci_reg + 1'b1 : '0;
    assign done      = !adv_same &&
                       (({1'b0, np} + {2'b0, k}) > {1'b0, len_reg});
    assign out_free  = !m_valid_reg || m_tready;
    assign stall     = (state_reg == ksf_pkg::ST_SCAN) && hit && pend_valid_reg && !out_free;

    assign count_inc = count_reg + 1'b1;
    assign start     = (head.item.op == ksf_pkg::OP_REF) && !count_reg[ksf_pkg::REF_COUNT_W-1] &&
                       (count_inc >= ksf_pkg::REF_COUNT_W'(k)) &&
                       (len_reg >= ksf_pkg::CONTIG_LEN_W'(k));

    assign head_pop  = (state_reg == ksf_pkg::ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign seed      = seed_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ksf_pkg::ST_IDLE: begin
                if (head.valid && start) begin
                    state_next = ksf_pkg::ST_SCAN;
                end
            end
            ksf_pkg::ST_SCAN: begin
                if (!stall && done) begin
                    state_next = (pend_valid_reg || hit) ? ksf_pkg::ST_FLUSH : ksf_pkg::ST_IDLE;
                end
            end
            ksf_pkg::ST_FLUSH: begin
                if (out_free) begin
                    state_next = ksf_pkg::ST_IDLE;
                end
            end
            default: state_next = ksf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        len_next        = len_reg;
        count_next      = count_reg;
        cp_next         = cp_reg;
        ci_next         = ci_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        rstart_next     = rstart_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        seed_next       = seed_reg;
        mem_we          = 1'b0;
        win_shift       = 1'b0;
        raddr           = ksf_pkg::CONTIG_ADDR_W'(cp_reg + ksf_pkg::CONTIG_LEN_W'(ci_reg));
        case (state_reg)
            ksf_pkg::ST_IDLE: begin
                if (head.valid) begin
                    case (head.item.op)
                        ksf_pkg::OP_CLEAR: begin
                            len_next   = '0;
                            count_next = '0;
                        end
                        ksf_pkg::OP_RESTART: begin
                            count_next = '0;
                        end
                        ksf_pkg::OP_CONTIG: begin
                            if (!len_reg[ksf_pkg::CONTIG_LEN_W-1]) begin
                                mem_we   = 1'b1;
                                len_next = len_reg + 1'b1;
                            end
                        end
                        ksf_pkg::OP_REF: begin
                            if (!count_reg[ksf_pkg::REF_COUNT_W-1]) begin
                                win_shift  = 1'b1;
                                count_next = count_inc;
                            end
                            if (start) begin
                                cp_next         = '0;
                                ci_next         = '0;
                                pend_valid_next = 1'b0;
                                rstart_next     = ksf_pkg::REF_POS_W'(count_inc -
                                                  ksf_pkg::REF_COUNT_W'(k));
                                raddr           = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ksf_pkg::ST_SCAN: begin
                if (!stall) begin
                    if (hit) begin
                        // previous hit is known not to be the last one now
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            seed_next    = make_seed(pend_reg, rstart_reg, k, 1'b0);
                        end
                        pend_next       = cp_reg[ksf_pkg::CONTIG_ADDR_W-1:0];
                        pend_valid_next = 1'b1;
                    end
                    cp_next = np;
                    ci_next = ni;
                    raddr   = ksf_pkg::CONTIG_ADDR_W'(np + ksf_pkg::CONTIG_LEN_W'(ni));
                end
            end
            ksf_pkg::ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    seed_next       = make_seed(pend_reg, rstart_reg, k, 1'b1);
                    pend_valid_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ksf_pkg::ST_IDLE;
            len_reg        <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cp_reg     <= cp_next;
        ci_reg     <= ci_next;
        pend_reg   <= pend_next;
        rstart_reg <= rstart_next;
        seed_reg   <= seed_next;
    end

    // contig store, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[len_reg[ksf_pkg::CONTIG_ADDR_W-1:0]] <= head.item.symbol;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (win_shift) begin
            for (int i = 0; i < ksf_pkg::MAX_KMER - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[ksf_pkg::MAX_KMER-1] <= head.item.symbol;
        end
    end

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ksf_pkg::ST_SCAN) |->
        (({1'b0, cp_reg} + {2'b0, k}) <= {1'b0, len_reg}))
        else $error("scan position past contig end");

    a_flush_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ksf_pkg::ST_FLUSH) |-> pend_valid_reg)
        else $error("flush without a pending seed");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> ($stable(cp_reg) && $stable(ci_reg) && $stable(pend_reg)))
        else $error("scan moved during output stall");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg <= ksf_pkg::REF_COUNT_W'(ksf_pkg::MAX_REFERENCE)) &&
        (len_reg <= ksf_pkg::CONTIG_LEN_W'(ksf_pkg::MAX_CONTIG)))
        else $error("reference count or contig length out of bound");

endmodule

`default_nettype wire

// ----- rtl/kmer_seed_finder.sv -----
// kmer_seed_finder: exact k-mer seed search of a reference stream in a stored contig
//
// cfg channel: cfg_data[5:0] is kmer_size, written on a cfg_valid beat (cfg_ready is
// always high); 0 acts as 1, above 32 acts as 32. write it only while the block is idle.
// s channel: s_tuser is the command (clear, contig char, reference char, restart),
// s_tdata the character. beats go into a four-entry queue, so input keeps flowing
// while the seed engine is busy or the result side is stalled.
// m channel: one beat per seed, in rising contig order; m_tlast marks the last seed
// caused by one reference character.
// flow: an accepted beat is stored in the queue and leaves it while the engine is idle. clear,
// restart, contig chars and reference chars that cannot seed are handled in the idle state. a
// reference char that starts a search moves the engine to the scan state, one character
// compare at a time (each contig position is compared until its first mismatch or k
// hits, at most 33 x 32 compares), then to the flush state to hand over the last seed if any.
// the scan is bound by the single read port of the contig store.
// the output register frees the engine when m_tready is high; while a seed waits,
// the scan holds at its next hit and the queue keeps taking beats until full.
// reset clears contig length, reference count, queue and output valid; kmer_size
// returns to 16. no clearing pass is needed.
`default_nettype none

module kmer_seed_finder (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ksf_pkg::KMER_W-1:0]     cfg_data,   // [5:0] kmer_size
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [ksf_pkg::SYMBOL_W-1:0]   s_tdata,    // [7:0] symbol
    input  wire logic [ksf_pkg::CMD_W-1:0]      s_tuser,    // [1:0] command
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [ksf_pkg::M_TDATA_W-1:0]       m_tdata,    // [5:0] contig_start,
                                                            // [11:6] contig_end,
                                                            // [27:12] ref_start,
                                                            // [43:28] ref_end
    output logic                                m_tlast     // last_seed
);

    logic [ksf_pkg::KMER_W-1:0] kmer_size_reg;
    logic [ksf_pkg::KMER_W-1:0] k_eff;
    ksf_pkg::qhead_t            head;
    logic                       head_pop;
    ksf_pkg::seed_t             seed;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kmer_size_reg <= ksf_pkg::KMER_W'(ksf_pkg::KMER_RESET);
        end else if (cfg_valid && cfg_ready) begin
            kmer_size_reg <= cfg_data;
        end
    end

    always_comb begin
        if (kmer_size_reg == '0) begin
            k_eff = ksf_pkg::KMER_W'(1);
        end else if (kmer_size_reg > ksf_pkg::KMER_W'(ksf_pkg::MAX_KMER)) begin
            k_eff = ksf_pkg::KMER_W'(ksf_pkg::MAX_KMER);
        end else begin
            k_eff = kmer_size_reg;
        end
    end

    ksf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .head     (head),
        .head_pop (head_pop)
    );

    ksf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .k        (k_eff),
        .head     (head),
        .head_pop (head_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .seed     (seed)
    );

    assign m_tdata = {4'b0, seed.ref_end, seed.ref_start, seed.contig_end, seed.contig_start};
    assign m_tlast = seed.last_seed;

endmodule

`default_nettype wire

// ----- tb/kmer_seed_finder_tb.sv -----
`timescale 1ns / 1ps

module kmer_seed_finder_tb;

    localparam int STALL_LIMIT   = 20000;
    // four queued beats plus the engine, each up to a full 33 x 32 compare scan
    localparam int SETTLE_CYCLES = 11000;
    localparam int PHASE_ITEMS   = 16;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [ksf_pkg::KMER_W-1:0]    cfg_data  = '0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [ksf_pkg::SYMBOL_W-1:0]  s_tdata   = '0;     // [7:0] symbol
    logic [ksf_pkg::CMD_W-1:0]     s_tuser   = '0;     // [1:0] command
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [ksf_pkg::M_TDATA_W-1:0] m_tdata;            // [5:0] contig_start, [11:6] contig_end,
                                                       // [27:12] ref_start, [43:28] ref_end
    logic                          m_tlast;            // last_seed

    kmer_seed_finder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    ksf_pkg::item_t               cmd_queue [$];
    ksf_pkg::seed_t               seed_queue [$];
    logic [ksf_pkg::SYMBOL_W-1:0] gen_contig [$];
    int                           queued_items  = 0;
    int                           send_idle_pct = 0;
    int                           recv_idle_pct = 0;
    int                           errors        = 0;
    int                           stall_cycles  = 0;

    // mirror of the block state
    logic [ksf_pkg::SYMBOL_W-1:0] contig_mem [ksf_pkg::MAX_CONTIG];
    logic [ksf_pkg::SYMBOL_W-1:0] ref_window [ksf_pkg::MAX_KMER];
    int                           contig_len = 0;
    int                           ref_count  = 0;
    logic [ksf_pkg::KMER_W-1:0]   kmer_reg   = ksf_pkg::KMER_W'(ksf_pkg::KMER_RESET);

    function automatic int eff_kmer();
        int kk;
        kk = int'(kmer_reg);
        if (kk < 1) kk = 1;
        if (kk > ksf_pkg::MAX_KMER) kk = ksf_pkg::MAX_KMER;
        return kk;
    endfunction

    task automatic predict_seeds(input ksf_pkg::op_t op,
                                 input logic [ksf_pkg::SYMBOL_W-1:0] sym);
        int             kk;
        int             start;
        bit             hit;
        bit             have;
        ksf_pkg::seed_t held;
        have = 1'b0;
        case (op)
            ksf_pkg::OP_CLEAR: begin
                contig_len = 0;
                ref_count  = 0;
            end
            ksf_pkg::OP_RESTART: begin
                ref_count = 0;
            end
            ksf_pkg::OP_CONTIG: begin
                if (contig_len < ksf_pkg::MAX_CONTIG) begin
                    contig_mem[contig_len] = sym;
                    contig_len++;
                end
            end
            default: begin
                if (ref_count < ksf_pkg::MAX_REFERENCE) begin
                    for (int i = 0; i < ksf_pkg::MAX_KMER - 1; i++) begin
                        ref_window[i] = ref_window[i + 1];
                    end
                    ref_window[ksf_pkg::MAX_KMER - 1] = sym;
                    ref_count++;
                    kk = eff_kmer();
                    if (ref_count >= kk && contig_len >= kk) begin
                        start = ref_count - kk;
                        for (int p = 0; p + kk <= contig_len; p++) begin
                            hit = 1'b1;
                            for (int i = 0; i < kk; i++) begin
                                if (contig_mem[p + i] !=
                                    ref_window[ksf_pkg::MAX_KMER - kk + i]) hit = 1'b0;
                            end
                            if (hit) begin
                                // hold one back so the final seed can carry the mark
                                if (have) seed_queue.insert(seed_queue.size(), held);
                                held.contig_start = ksf_pkg::CONTIG_ADDR_W'(p);
                                held.contig_end   = ksf_pkg::CONTIG_ADDR_W'(p + kk - 1);
                                held.ref_start    = ksf_pkg::REF_POS_W'(start);
                                held.ref_end      = ksf_pkg::REF_POS_W'(start + kk - 1);
                                held.last_seed    = 1'b0;
                                have = 1'b1;
                            end
                        end
                        if (have) begin
                            held.last_seed = 1'b1;
                            seed_queue.insert(seed_queue.size(), held);
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10) $display("%s", msg);
    endtask

    // driver
    always @(posedge aclk) begin
        ksf_pkg::item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = cmd_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.op;
                s_tdata  <= nxt.symbol;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor, checker and watchdog
    always @(posedge aclk) begin
        ksf_pkg::seed_t got;
        ksf_pkg::seed_t want;
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_seeds(ksf_pkg::op_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready) begin
                got = {m_tlast, m_tdata[$bits(ksf_pkg::seed_t)-2:0]};
                if (seed_queue.size() == 0) begin
                    flag_error($sformatf("unexpected seed: cs=%0d ce=%0d rs=%0d re=%0d last=%0b",
                        got.contig_start, got.contig_end, got.ref_start, got.ref_end,
                        got.last_seed));
                end else begin
                    want = seed_queue.pop_front();
                    if (got.contig_start != want.contig_start || got.contig_end != want.contig_end
                        || got.ref_start != want.ref_start || got.ref_end != want.ref_end
                        || got.last_seed != want.last_seed) begin
                        flag_error($sformatf({"seed mismatch: expected cs=%0d ce=%0d rs=%0d",
                            " re=%0d last=%0b, got cs=%0d ce=%0d rs=%0d re=%0d last=%0b"},
                            want.contig_start, want.contig_end, want.ref_start, want.ref_end,
                            want.last_seed, got.contig_start, got.contig_end, got.ref_start,
                            got.ref_end, got.last_seed));
                    end
                end
            end
            // only count while something is still owed by either side
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                || !(cmd_queue.size() > 0 || s_tvalid || seed_queue.size() > 0)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic push_item(input ksf_pkg::op_t op, input logic [ksf_pkg::SYMBOL_W-1:0] sym);
        ksf_pkg::item_t itm;
        itm.op     = op;
        itm.symbol = sym;
        cmd_queue.insert(cmd_queue.size(), itm);
        queued_items++;
    endtask

    task automatic write_kmer(input logic [ksf_pkg::KMER_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        kmer_reg = value;
    endtask

    task automatic settle();
        while (cmd_queue.size() > 0 || s_tvalid || seed_queue.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_random_burst();
        logic [ksf_pkg::SYMBOL_W-1:0] alpha [4];
        int                           kk;
        int                           nalpha;
        int                           clen;
        int                           rlen;
        int                           at;
        bit                           copy;
        kk     = eff_kmer();
        nalpha = $urandom_range(1, 4);
        foreach (alpha[i]) alpha[i] = ksf_pkg::SYMBOL_W'($urandom);
        if ($urandom_range(99) < 20) begin
            // noise: any command with any byte
            repeat ($urandom_range(1, 4)) begin
                push_item(ksf_pkg::op_t'($urandom_range(3)), ksf_pkg::SYMBOL_W'($urandom));
            end
        end else begin
            if (gen_contig.size() == 0 || $urandom_range(99) < 70) begin
                // new contig, sometimes past capacity, often shorter than k
                if ($urandom_range(99) < 15) clen = $urandom_range(60, 70);
                else clen = $urandom_range(1, kk + 6);
                gen_contig.delete();
                push_item(ksf_pkg::OP_CLEAR, ksf_pkg::SYMBOL_W'($urandom));
                repeat (clen) begin
                    gen_contig.insert(gen_contig.size(), alpha[$urandom_range(nalpha - 1)]);
                    push_item(ksf_pkg::OP_CONTIG, gen_contig[$]);
                end
            end else begin
                push_item(ksf_pkg::OP_RESTART, ksf_pkg::SYMBOL_W'($urandom));
            end
            if ($urandom_range(99) < 20) rlen = $urandom_range(1, kk);
            else rlen = kk + $urandom_range(0, 6);
            copy = 1'($urandom_range(1));
            at   = $urandom_range(gen_contig.size() - 1);
            for (int i = 0; i < rlen; i++) begin
                if (copy && at + i < gen_contig.size()) begin
                    push_item(ksf_pkg::OP_REF, gen_contig[at + i]);
                end else begin
                    push_item(ksf_pkg::OP_REF, alpha[$urandom_range(nalpha - 1)]);
                end
            end
        end
    endtask

    task automatic run_random_phase();
        int base;
        @(negedge aclk);
        base = queued_items;
        while (queued_items - base < PHASE_ITEMS) queue_random_burst();
        settle();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset k of 16: a full-length match over bytes from 0x00 up to 0xff
        send_idle_pct = 22;
        recv_idle_pct = 69;
        @(negedge aclk);
        push_item(ksf_pkg::OP_CLEAR, 8'h00);
        for (int i = 0; i < 16; i++) push_item(ksf_pkg::OP_CONTIG, ksf_pkg::SYMBOL_W'(i * 17));
        for (int i = 0; i < 16; i++) push_item(ksf_pkg::OP_REF, ksf_pkg::SYMBOL_W'(i * 17));
        push_item(ksf_pkg::OP_RESTART, 8'hff);
        settle();

        write_kmer(ksf_pkg::KMER_W'(1));
        run_random_phase();

        send_idle_pct = 69;
        recv_idle_pct = 22;
        write_kmer(ksf_pkg::KMER_W'(0));
        run_random_phase();
        write_kmer(ksf_pkg::KMER_W'(ksf_pkg::MAX_KMER));
        run_random_phase();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_kmer(ksf_pkg::KMER_W'(63));
        run_random_phase();
        write_kmer(ksf_pkg::KMER_W'($urandom_range(2, 31)));
        run_random_phase();

        // repeated contig bytes: several seeds per reference beat, then a restart
        write_kmer(ksf_pkg::KMER_W'(5));
        @(negedge aclk);
        push_item(ksf_pkg::OP_CLEAR, 8'h00);
        repeat (6) push_item(ksf_pkg::OP_CONTIG, 8'ha5);
        repeat (6) push_item(ksf_pkg::OP_REF, 8'ha5);
        push_item(ksf_pkg::OP_REF, 8'h3c);
        push_item(ksf_pkg::OP_RESTART, 8'h00);
        repeat (5) push_item(ksf_pkg::OP_REF, 8'ha5);
        settle();

        if (errors == 0 && seed_queue.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ksf_pkg.sv
rtl/ksf_front.sv
rtl/ksf_back.sv
rtl/kmer_seed_finder.sv
tb/kmer_seed_finder_tb.sv
